FILE: rtl/core/stm_pkg.sv
// Shared types and constants for the system call trace monitor.
// Used by the monitor core; no dependencies of its own.
`default_nettype none

package stm_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int HIST_ENTRIES_DEF = 512;
  localparam int RING_ENTRIES_DEF = 128;
  localparam int COUNT_BITS_DEF   = 32;

  // Configuration port widths.
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  // Reset values and the lower edge of the error band (-4095 as unsigned).
  localparam logic [31:0] THRESHOLD_RST   = 32'd2000;
  localparam logic [31:0] PREV_NUMBER_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] ERR_LOW         = 32'hFFFF_F001;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LIVELOCK_THRESHOLD = 8'd0,
    CFG_RING_ENABLE        = 8'd1
  } cfg_reg_t;

  // One traced call as it arrives.
  typedef struct packed {
    logic [31:0] call_number;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic [31:0] arg2;
    logic [31:0] arg3;
    logic [31:0] arg4;
    logic [31:0] arg5;
    logic [31:0] return_value;
    logic [63:0] call_index;
    logic [63:0] cycle_stamp;
  } stm_in_t;

  // One result word.
  typedef struct packed {
    logic        livelock;
    logic [31:0] repeat_count;
    logic        is_error;
    logic [31:0] hist_calls;
    logic [31:0] hist_errors;
    logic [6:0]  ring_slot;
    logic [31:0] recorded_total;
  } stm_out_t;

  // One entry of the ring of recent calls.
  typedef struct packed {
    logic [31:0] number;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic [31:0] arg2;
    logic [31:0] arg3;
    logic [31:0] arg4;
    logic [31:0] arg5;
    logic [31:0] ret;
    logic [63:0] index;
    logic [63:0] cycle;
    logic        error;
  } ring_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/stm_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read during a write to the same address returns the old contents.
`default_nettype none

module stm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/syscall_trace_monitor_core.sv
// System call trace monitor: livelock repeat detection, per-number histogram, call ring.
// Path: an accepted call passes the stage 1 register (histogram read), then the output
// register, which raises out_valid. Throughput: one word per cycle while out_ready holds,
// set by the histogram read-modify-write, which forwards the last write to the next read.
// Reset: a clearing pass zeroes the histogram memory with in_ready low; the configuration
// port accepts writes throughout. Depends on stm_pkg and stm_ram.
`default_nettype none

module syscall_trace_monitor_core
  import stm_pkg::*;
#(
  parameter int HIST_ENTRIES = HIST_ENTRIES_DEF,
  parameter int RING_ENTRIES = RING_ENTRIES_DEF,
  parameter int COUNT_BITS   = COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Input channel
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire stm_in_t                in_data,
  // Result channel
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output stm_out_t                    out_data,
  // Configuration channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int HIST_AW = $clog2(HIST_ENTRIES);
  localparam int RING_AW = $clog2(RING_ENTRIES);
  localparam int HIST_W  = 2 * COUNT_BITS + 32;
  localparam int CMP_W   = (COUNT_BITS > 32) ? COUNT_BITS : 32;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration registers.
  logic [31:0] thresh_r;
  logic        ring_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= THRESHOLD_RST;
      ring_en_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIVELOCK_THRESHOLD: thresh_r  <= cfg_data;
        CFG_RING_ENABLE:        ring_en_r <= cfg_data[0];
        default:                ;
      endcase
    end
  end

  // Histogram clearing pass after reset.
  logic               clr_active_r;
  logic [HIST_AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == HIST_AW'(HIST_ENTRIES - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  // Handshake control.
  logic s1_valid_r;
  logic out_valid_r;
  logic out_load;
  logic accept;

  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clr_active_r && (!s1_valid_r || out_load);
  assign accept   = in_valid && in_ready;

  // Livelock detection, resolved at accept.
  logic [31:0]           prev_number_r, prev_return_r;
  logic [31:0]           prev_args_r [6];
  logic [COUNT_BITS-1:0] rep_cnt_r, rep_cnt_nxt;
  logic                  same_call;
  logic                  live_nxt;
  logic                  take_ref;

  always_comb begin
    same_call = (in_data.call_number == prev_number_r) &&
                (in_data.return_value == prev_return_r) &&
                (in_data.arg0 == prev_args_r[0]) && (in_data.arg1 == prev_args_r[1]) &&
                (in_data.arg2 == prev_args_r[2]) && (in_data.arg3 == prev_args_r[3]) &&
                (in_data.arg4 == prev_args_r[4]) && (in_data.arg5 == prev_args_r[5]);
    rep_cnt_nxt = rep_cnt_r;
    live_nxt    = 1'b0;
    take_ref    = 1'b0;
    if (thresh_r != '0) begin
      if (same_call) begin
        rep_cnt_nxt = (rep_cnt_r == COUNT_MAX) ? rep_cnt_r : rep_cnt_r + 1'b1;
        live_nxt    = CMP_W'(rep_cnt_nxt) >= CMP_W'(thresh_r);
      end else begin
        rep_cnt_nxt = '0;
        take_ref    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_number_r <= PREV_NUMBER_RST;
      prev_return_r <= '0;
      prev_args_r   <= '{default: '0};
      rep_cnt_r     <= '0;
    end else if (accept) begin
      rep_cnt_r <= rep_cnt_nxt;
      if (take_ref) begin
        prev_number_r  <= in_data.call_number;
        prev_return_r  <= in_data.return_value;
        prev_args_r[0] <= in_data.arg0;
        prev_args_r[1] <= in_data.arg1;
        prev_args_r[2] <= in_data.arg2;
        prev_args_r[3] <= in_data.arg3;
        prev_args_r[4] <= in_data.arg4;
        prev_args_r[5] <= in_data.arg5;
      end
    end
  end

  // Ring write pointer and write total, advanced at accept.
  logic [RING_AW-1:0] head_r, head_nxt;
  logic [31:0]        total_r, total_nxt;
  logic               is_err;
  logic               ring_we;
  ring_entry_t        ring_wdata;

  assign is_err  = in_data.return_value >= ERR_LOW;
  assign ring_we = accept && ring_en_r;

  always_comb begin
    head_nxt  = (head_r == RING_AW'(RING_ENTRIES - 1)) ? '0 : head_r + 1'b1;
    total_nxt = (total_r == '1) ? total_r : total_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      total_r <= '0;
    end else if (ring_we) begin
      head_r  <= head_nxt;
      total_r <= total_nxt;
    end
  end

  always_comb begin
    ring_wdata.number = in_data.call_number;
    ring_wdata.arg0   = in_data.arg0;
    ring_wdata.arg1   = in_data.arg1;
    ring_wdata.arg2   = in_data.arg2;
    ring_wdata.arg3   = in_data.arg3;
    ring_wdata.arg4   = in_data.arg4;
    ring_wdata.arg5   = in_data.arg5;
    ring_wdata.ret    = in_data.return_value;
    ring_wdata.index  = in_data.call_index;
    ring_wdata.cycle  = in_data.cycle_stamp;
    ring_wdata.error  = is_err;
  end

  // The ring is write-only within this block.
  stm_ram #(
    .WIDTH($bits(ring_entry_t)),
    .DEPTH(RING_ENTRIES)
  ) u_ring_ram (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (head_r),
    .wr_data (ring_wdata),
    .rd_en   (1'b0),
    .rd_addr ('0),
    .rd_data ()
  );

  // Histogram memory: calls, errors and last return per call number.
  logic               hist_rd;
  logic               hist_we;
  logic [HIST_AW-1:0] hist_waddr;
  logic [HIST_W-1:0]  hist_wdata;
  logic [HIST_W-1:0]  hist_rdata;
  logic [HIST_W-1:0]  hist_new;
  logic               in_hist;

  assign in_hist = ring_en_r && (in_data.call_number < 32'(HIST_ENTRIES));
  assign hist_rd = accept && in_hist;

  stm_ram #(
    .WIDTH(HIST_W),
    .DEPTH(HIST_ENTRIES)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_en   (hist_rd),
    .rd_addr (in_data.call_number[HIST_AW-1:0]),
    .rd_data (hist_rdata)
  );

  // Stage 1 registers: the item whose histogram entry is being read.
  logic               s1_live_r;
  logic [31:0]        s1_rep_r;
  logic               s1_err_r;
  logic               s1_hist_r;
  logic [HIST_AW-1:0] s1_addr_r;
  logic [31:0]        s1_ret_r;
  logic [6:0]         s1_slot_r;
  logic [31:0]        s1_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_live_r  <= live_nxt;
      s1_rep_r   <= 32'(rep_cnt_nxt);
      s1_err_r   <= is_err;
      s1_hist_r  <= in_hist;
      s1_addr_r  <= in_data.call_number[HIST_AW-1:0];
      s1_ret_r   <= in_data.return_value;
      s1_slot_r  <= ring_en_r ? 7'(head_r) : '0;
      s1_total_r <= ring_en_r ? total_nxt : total_r;
    end
  end

  // Forwarding of the most recent histogram write.
  logic               fwd_valid_r;
  logic [HIST_AW-1:0] fwd_addr_r;
  logic [HIST_W-1:0]  fwd_data_r;
  logic [HIST_W-1:0]  hist_old;
  logic [COUNT_BITS-1:0] old_calls, old_errs, new_calls, new_errs;

  always_comb begin
    hist_old  = (fwd_valid_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : hist_rdata;
    old_calls = hist_old[HIST_W-1 -: COUNT_BITS];
    old_errs  = hist_old[32 +: COUNT_BITS];
    new_calls = (old_calls == COUNT_MAX) ? old_calls : old_calls + 1'b1;
    new_errs  = (s1_err_r && old_errs != COUNT_MAX) ? old_errs + 1'b1 : old_errs;
    hist_new  = {new_calls, new_errs, s1_ret_r};
  end

  // Write port: the clearing pass, then stage 1 as it retires.
  always_comb begin
    if (clr_active_r) begin
      hist_we    = 1'b1;
      hist_waddr = clr_addr_r;
      hist_wdata = '0;
    end else begin
      hist_we    = out_load && s1_hist_r;
      hist_waddr = s1_addr_r;
      hist_wdata = hist_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr_active_r) begin
      fwd_valid_r <= 1'b0;
    end else if (hist_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      fwd_addr_r <= hist_waddr;
      fwd_data_r <= hist_wdata;
    end
  end

  // Output register.
  stm_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.livelock       <= s1_live_r;
      out_data_r.repeat_count   <= s1_rep_r;
      out_data_r.is_error       <= s1_err_r;
      out_data_r.hist_calls     <= s1_hist_r ? 32'(new_calls) : '0;
      out_data_r.hist_errors    <= s1_hist_r ? 32'(new_errs) : '0;
      out_data_r.ring_slot      <= s1_slot_r;
      out_data_r.recorded_total <= s1_total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // No call enters while the histogram is being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_ready)
    else $error("input accepted during histogram clearing pass");

  // Outside the clearing pass, only a retiring stage 1 item writes the histogram.
  a_hist_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    (hist_we && !clr_active_r) |-> (s1_valid_r && out_load))
    else $error("histogram written without a retiring item");

  // Forwarding never carries data from the clearing pass into a lookup.
  a_fwd_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(clr_active_r) |-> !fwd_valid_r)
    else $error("forwarding register live at end of clearing pass");
`endif

endmodule

`default_nettype wire

FILE: dv/stm_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the system call trace monitor: watches the call, result and register
// channels, predicts every result word and compares it field by field. Depends on stm_pkg.

module stm_checker
  import stm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire stm_in_t                in_data,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire stm_out_t               out_data,
  input  wire logic                   cfg_valid,
  input  wire logic                   cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output int                          errors,
  output int                          pending,
  output int                          calls_seen,
  output int                          live_seen,
  output int                          err_seen
);

  localparam int          HIST_DEPTH  = 512;
  localparam logic [31:0] ERR_BAND_LO = 32'hFFFF_F001;
  localparam logic [31:0] SAT_MAX     = 32'hFFFF_FFFF;
  localparam int          PRINT_CAP   = 100;
  localparam int          OUT_W       = $bits(stm_out_t);

  // Shadow copy of the register file.
  logic [31:0]  threshold;
  logic         ring_on;

  // Reference call for repeat detection, plus its repeat counter.
  logic [31:0]  ref_number;
  logic [191:0] ref_args;
  logic [31:0]  ref_ret;
  logic [31:0]  repeats;

  // Per-number histogram counts and the ring bookkeeping.
  logic [31:0]  calls_per_nr [HIST_DEPTH];
  logic [31:0]  errs_per_nr  [HIST_DEPTH];
  logic [31:0]  ring_written;
  logic [6:0]   ring_ptr;

  stm_out_t     expected_q [$];

  // One line per mismatch; printing stops after a cap but counting goes on.
  task automatic report_mismatch(input string what,
                                 input logic [OUT_W-1:0] got,
                                 input logic [OUT_W-1:0] want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // Work out the result word of one call and advance the shadow state.
  function automatic stm_out_t predict_result(input stm_in_t c);
    stm_out_t     r;
    logic [191:0] args;
    logic         in_band;
    logic [8:0]   slot;
    r       = '0;
    args    = {c.arg0, c.arg1, c.arg2, c.arg3, c.arg4, c.arg5};
    in_band = c.return_value >= ERR_BAND_LO;
    slot    = c.call_number[8:0];
    r.is_error = in_band;

    if (threshold != 32'd0) begin
      if (c.call_number == ref_number && c.return_value == ref_ret && args == ref_args) begin
        if (repeats != SAT_MAX) repeats++;
        r.livelock = repeats >= threshold;
      end else begin
        repeats    = '0;
        ref_number = c.call_number;
        ref_ret    = c.return_value;
        ref_args   = args;
      end
    end
    r.repeat_count = repeats;

    if (ring_on) begin
      if (c.call_number < 32'(HIST_DEPTH)) begin
        if (calls_per_nr[slot] != SAT_MAX) calls_per_nr[slot]++;
        if (in_band && errs_per_nr[slot] != SAT_MAX) errs_per_nr[slot]++;
        r.hist_calls  = calls_per_nr[slot];
        r.hist_errors = errs_per_nr[slot];
      end
      r.ring_slot = ring_ptr;
      ring_ptr++;
      if (ring_written != SAT_MAX) ring_written++;
    end
    r.recorded_total = ring_written;
    return r;
  endfunction

  // Compare one result word against the oldest prediction.
  task automatic check_result(input stm_out_t got);
    stm_out_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result word with nothing expected", got, '0);
      return;
    end
    want = expected_q.pop_front();
    calls_seen++;
    if (want.livelock) live_seen++;
    if (got.livelock !== want.livelock)
      report_mismatch("livelock", OUT_W'(got.livelock), OUT_W'(want.livelock));
    if (got.repeat_count !== want.repeat_count)
      report_mismatch("repeat_count", OUT_W'(got.repeat_count), OUT_W'(want.repeat_count));
    if (got.is_error !== want.is_error)
      report_mismatch("is_error", OUT_W'(got.is_error), OUT_W'(want.is_error));
    if (got.hist_calls !== want.hist_calls)
      report_mismatch("hist_calls", OUT_W'(got.hist_calls), OUT_W'(want.hist_calls));
    if (got.hist_errors !== want.hist_errors)
      report_mismatch("hist_errors", OUT_W'(got.hist_errors), OUT_W'(want.hist_errors));
    if (got.ring_slot !== want.ring_slot)
      report_mismatch("ring_slot", OUT_W'(got.ring_slot), OUT_W'(want.ring_slot));
    if (got.recorded_total !== want.recorded_total)
      report_mismatch("recorded_total", OUT_W'(got.recorded_total),
                      OUT_W'(want.recorded_total));
  endtask

  // All channels are sampled at the rising edge; inputs move on the falling edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      threshold    = THRESHOLD_RST;
      ring_on      = 1'b0;
      ref_number   = 32'hFFFF_FFFF;
      ref_args     = '0;
      ref_ret      = '0;
      repeats      = '0;
      ring_written = '0;
      ring_ptr     = '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
        calls_per_nr[i] = '0;
        errs_per_nr[i]  = '0;
      end
      expected_q.delete();
    end else begin
      // Register writes arrive only while no call is in flight.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_LIVELOCK_THRESHOLD: threshold = cfg_data;
          CFG_RING_ENABLE:        ring_on   = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) begin
        if (in_data.return_value >= ERR_BAND_LO) err_seen++;
        expected_q.push_back(predict_result(in_data));
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the system call trace monitor: clock, reset, call and register stimulus
// and the verdict. Depends on stm_pkg, syscall_trace_monitor_core and stm_checker.

module tb;
  import stm_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 6;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 165;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_SUCH_REG = '1;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  stm_in_t                in_data;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  stm_out_t               out_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  int          snd_idle;
  int          rcv_idle;
  logic [31:0] cur_thr;
  int          n_settings;
  int          stall_cycles;
  int          errors, pending, calls_seen, live_seen, err_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  syscall_trace_monitor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  stm_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .calls_seen (calls_seen),
    .live_seen  (live_seen),
    .err_seen   (err_seen)
  );

  // Result side back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  // Watchdog: give up after too many cycles without any handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  // Present one call word and hold it until the monitor takes it.
  task automatic send_call(input stm_in_t c);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait until every predicted result has come back, then let the pipeline settle.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_config(input logic [31:0] thr, input logic [31:0] en_word);
    drain();
    write_reg(CFG_LIVELOCK_THRESHOLD, thr);
    write_reg(CFG_RING_ENABLE, en_word);
    cur_thr = thr;
    n_settings++;
  endtask

  function automatic stm_in_t mk_call(input logic [31:0] nr, input logic [31:0] a,
                                      input logic [31:0] ret);
    stm_in_t c;
    c.call_number  = nr;
    c.arg0         = a;
    c.arg1         = a;
    c.arg2         = a;
    c.arg3         = a;
    c.arg4         = a;
    c.arg5         = a;
    c.return_value = ret;
    c.call_index   = {$urandom, $urandom};
    c.cycle_stamp  = {$urandom, $urandom};
    return c;
  endfunction

  // Numbers cluster on a few histogram rows, with the row edges and wide values mixed in.
  function automatic logic [31:0] pick_number();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - $urandom_range(2);
      2:       return 32'd512 + $urandom_range(7);
      3:       return 32'd511 - $urandom_range(7);
      default: return $urandom_range(15);
    endcase
  endfunction

  function automatic logic [31:0] pick_ret();
    case ($urandom_range(7))
      0:       return 32'd0 - $urandom_range(4095, 1);
      1:       return 32'hFFFF_F000 + $urandom_range(2);
      2:       return 32'hFFFF_FFFF;
      3:       return $urandom;
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic logic [31:0] pick_arg();
    if ($urandom_range(3) == 0) return $urandom_range(3);
    return $urandom;
  endfunction

  function automatic stm_in_t rand_call();
    stm_in_t c;
    c.call_number  = pick_number();
    c.arg0         = pick_arg();
    c.arg1         = pick_arg();
    c.arg2         = pick_arg();
    c.arg3         = pick_arg();
    c.arg4         = pick_arg();
    c.arg5         = pick_arg();
    c.return_value = pick_ret();
    c.call_index   = {$urandom, $urandom};
    c.cycle_stamp  = {$urandom, $urandom};
    return c;
  endfunction

  // Same call with one bit flipped in one compared field.
  function automatic stm_in_t near_miss(input stm_in_t c);
    stm_in_t m;
    int      b;
    m = c;
    b = $urandom_range(31);
    case ($urandom_range(7))
      0:       m.call_number[b]  = ~m.call_number[b];
      1:       m.arg0[b]         = ~m.arg0[b];
      2:       m.arg1[b]         = ~m.arg1[b];
      3:       m.arg2[b]         = ~m.arg2[b];
      4:       m.arg3[b]         = ~m.arg3[b];
      5:       m.arg4[b]         = ~m.arg4[b];
      6:       m.arg5[b]         = ~m.arg5[b];
      default: m.return_value[b] = ~m.return_value[b];
    endcase
    m.call_index = {$urandom, $urandom};
    return m;
  endfunction

  // Mostly runs of identical calls that can cross a threshold up to eight, some near misses.
  task automatic run_traffic(input int n);
    stm_in_t base;
    stm_in_t c;
    int      sent;
    int      reps;
    int      rep_hi;
    sent   = 0;
    rep_hi = (cur_thr != 32'd0 && cur_thr <= 32'd8) ? int'(cur_thr) + 3 : 6;
    while (sent < n) begin
      base = rand_call();
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: begin
          reps = $urandom_range(rep_hi, 1);
          for (int k = 0; k < reps; k++) begin
            c             = base;
            c.call_index  = {$urandom, $urandom};
            c.cycle_stamp = {$urandom, $urandom};
            send_call(c);
          end
          sent += reps;
        end
        6, 7: begin
          send_call(base);
          send_call(base);
          send_call(near_miss(base));
          sent += 3;
        end
        default: begin
          send_call(base);
          sent++;
        end
      endcase
    end
  endtask

  function automatic logic [31:0] phase_threshold(input int p);
    case (p)
      0:       return 32'd1;
      1:       return 32'd2;
      2:       return 32'd0;
      3:       return 32'd5;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'd3;
      6:       return 32'd1;
      7:       return 32'd4;
      default: return THRESHOLD_RST;
    endcase
  endfunction

  // Ring enable data, with the upper bits set in some phases; only bit zero counts.
  function automatic logic [31:0] phase_enable(input int p);
    case (p)
      3:       return 32'hFFFF_FFFE;
      6:       return 32'd0;
      4:       return 32'hFFFF_FFFF;
      default: return 32'd1;
    endcase
  endfunction

  initial begin
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    rst_n      = 1'b0;
    snd_idle   = 0;
    rcv_idle   = 0;
    cur_thr    = THRESHOLD_RST;
    n_settings = 1;
    stall_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: an all-ones number with zero arguments matches the reset reference.
    send_call(mk_call(32'hFFFF_FFFF, 32'd0, 32'd0));
    send_call(mk_call(32'hFFFF_FFFF, 32'd0, 32'd0));
    send_call(mk_call(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    // A write to an index with no register behind it must change nothing.
    drain();
    write_reg(CFG_NO_SUCH_REG, 32'hFFFF_FFFF);
    send_call(mk_call(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    // Lowest threshold with recording: error band edges, histogram edges, out-of-range numbers.
    set_config(32'd1, 32'd1);
    send_call(mk_call(32'd0, 32'd0, 32'hFFFF_F001));
    send_call(mk_call(32'd0, 32'd0, 32'hFFFF_F001));
    send_call(mk_call(32'd511, 32'h5555_5555, 32'hFFFF_F000));
    send_call(mk_call(32'd512, 32'hAAAA_AAAA, 32'h7FFF_FFFF));
    send_call(mk_call(32'hFFFF_FFFF, 32'd0, 32'h8000_0000));
    send_call(mk_call(32'd511, 32'd1, 32'hFFFF_FFFF));
    send_call(mk_call(32'd511, 32'd1, 32'hFFFF_FFFF));

    // Detection off: the counter and reference hold.
    set_config(32'd0, 32'hFFFF_FFFF);
    send_call(mk_call(32'd511, 32'd1, 32'hFFFF_FFFF));
    send_call(mk_call(32'd7, 32'd2, 32'd0));

    // Largest threshold never fires.
    set_config(32'hFFFF_FFFF, 32'd1);
    send_call(mk_call(32'd7, 32'd2, 32'd0));
    send_call(mk_call(32'd7, 32'd2, 32'd0));
    send_call(mk_call(32'd7, 32'd2, 32'd0));

    // Recording off, flag on the second repeat.
    set_config(32'd2, 32'hFFFF_FFFE);
    repeat (4) send_call(mk_call(32'd3, 32'd3, 32'd3));

    // Random phases; the idling pattern changes every third phase.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p / 3)
        0: begin
          snd_idle = 12;
          rcv_idle = 76;
        end
        1: begin
          snd_idle = 76;
          rcv_idle = 12;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      set_config(phase_threshold(p), phase_enable(p));
      run_traffic(PHASE_ITEMS);
    end

    drain();
    $display("summary: %0d calls checked over %0d register settings", calls_seen, n_settings);
    $display("summary: %0d livelock flags, %0d returns in the error band", live_seen, err_seen);
    if (errors == 0 && pending == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/stm_pkg.sv
rtl/core/stm_ram.sv
rtl/core/syscall_trace_monitor_core.sv
dv/stm_checker.sv
dv/tb.sv
